// File: hw/rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// Command frame deframer package
// Shared constants, codes and the result record passed between modules.
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam int BUFFER_BYTES_DEF = 128;
   localparam int HEADER_BYTES     = 5;

   localparam logic [7:0] START_MARKER_RST = 8'd170;
   localparam logic [7:0] END_MARKER_RST   = 8'd85;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_START_MARKER = 1'b0;
   localparam logic REG_END_MARKER   = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_END_MARK = 2'd2,
      STATUS_DROPPED  = 2'd3
   } status_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [6:0] payload_position;
      logic [7:0] frame_type;
      logic [7:0] unit_index;
      logic [15:0] payload_length;
      status_type frame_status;
   } result_type;

   localparam int RSP_TDATA_W = 56;
   localparam int REQ_TDATA_W = 8;

endpackage

// File: hw/rtl/cfd_csr.sv
// ----------------------------------------------------------------------------
// Command frame deframer register file
// APB-style access to the start and end marker registers.
// ----------------------------------------------------------------------------
module cfd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cfd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cfd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cfd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [7:0]                       start_marker,
   output logic [7:0]                       end_marker
);

   logic [7:0] start_marker_ff;
   logic [7:0] start_marker_in;
   logic [7:0] end_marker_ff;
   logic [7:0] end_marker_in;
   logic       wr_en;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      if (wr_en) begin
         case (reg_sel)
            cfd_pkg::REG_START_MARKER: start_marker_in = csr_pwdata[7:0];
            cfd_pkg::REG_END_MARKER:   end_marker_in   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= cfd_pkg::START_MARKER_RST;
         end_marker_ff   <= cfd_pkg::END_MARKER_RST;
      end else begin
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
      end
   end

   always_comb begin
      case (reg_sel)
         cfd_pkg::REG_START_MARKER: csr_prdata = {24'd0, start_marker_ff};
         cfd_pkg::REG_END_MARKER:   csr_prdata = {24'd0, end_marker_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   assign start_marker = start_marker_ff;
   assign end_marker   = end_marker_ff;

endmodule

// File: hw/rtl/cfd_parser.sv
// ----------------------------------------------------------------------------
// Command frame deframer parser
// Frame state and the per-byte step: header capture, XOR, verdict.
// ----------------------------------------------------------------------------
module cfd_parser #(
   parameter int BUFFER_BYTES = cfd_pkg::BUFFER_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           start_marker,
   input  logic [7:0]           end_marker,
   output logic                 res_valid,
   output cfd_pkg::result_type  res
);

   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_BYTES);
   localparam logic [16:0] HDR = 17'(cfd_pkg::HEADER_BYTES);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [7:0]       xor_ff;
   logic [7:0]       xor_in;
   logic [7:0]       type_ff;
   logic [7:0]       type_in;
   logic [7:0]       index_ff;
   logic [7:0]       index_in;
   logic [15:0]      length_ff;
   logic [15:0]      length_in;
   logic [7:0]       checksum_ff;
   logic [7:0]       checksum_in;

   logic [CNT_W-1:0] count_inc;
   logic [16:0]      pos_w;
   logic [16:0]      payload_end;
   logic [16:0]      offset;

   assign count_inc   = count_ff + CNT_W'(1);
   assign pos_w       = 17'(count_ff);
   assign payload_end = HDR + {1'b0, length_ff};
   assign offset      = pos_w - HDR;

   always_comb begin
      count_in    = count_ff;
      xor_in      = xor_ff;
      type_in     = type_ff;
      index_in    = index_ff;
      length_in   = length_ff;
      checksum_in = checksum_ff;
      res_valid   = 1'b0;
      res.kind             = cfd_pkg::KIND_PAYLOAD;
      res.payload_byte     = 8'd0;
      res.payload_position = 7'd0;
      res.frame_type       = type_ff;
      res.unit_index       = index_ff;
      res.payload_length   = length_ff;
      res.frame_status     = cfd_pkg::STATUS_GOOD;

      if (step_en) begin
         if (count_ff == '0) begin
            if (rx_byte == start_marker) begin
               count_in    = CNT_W'(1);
               xor_in      = 8'd0;
               type_in     = 8'd0;
               index_in    = 8'd0;
               length_in   = 16'd0;
               checksum_in = 8'd0;
            end
         end else if (pos_w > payload_end) begin
            // End marker position: checksum mismatch wins over a bad marker.
            res_valid = 1'b1;
            res.kind  = cfd_pkg::KIND_VERDICT;
            if (xor_ff != checksum_ff) begin
               res.frame_status = cfd_pkg::STATUS_CHECKSUM;
            end else if (rx_byte != end_marker) begin
               res.frame_status = cfd_pkg::STATUS_END_MARK;
            end
            count_in = '0;
         end else begin
            count_in = count_inc;
            if (pos_w == 17'd1) begin
               type_in = rx_byte;
               xor_in  = xor_ff ^ rx_byte;
            end else if (pos_w == 17'd2) begin
               index_in = rx_byte;
               xor_in   = xor_ff ^ rx_byte;
            end else if (pos_w == 17'd3) begin
               length_in = {rx_byte, length_ff[7:0]};
               xor_in    = xor_ff ^ rx_byte;
            end else if (pos_w == 17'd4) begin
               length_in = {length_ff[15:8], rx_byte};
               xor_in    = xor_ff ^ rx_byte;
            end else if (pos_w < payload_end) begin
               xor_in               = xor_ff ^ rx_byte;
               res_valid            = 1'b1;
               res.payload_byte     = rx_byte;
               res.payload_position = offset[6:0];
            end else begin
               checksum_in = rx_byte;
            end
            // A frame that fills the buffer is dropped in place of this byte.
            if (count_inc >= CNT_LIMIT) begin
               res_valid            = 1'b1;
               res.kind             = cfd_pkg::KIND_VERDICT;
               res.payload_byte     = 8'd0;
               res.payload_position = 7'd0;
               res.frame_status     = cfd_pkg::STATUS_DROPPED;
               count_in             = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      xor_ff      <= xor_in;
      type_ff     <= type_in;
      index_ff    <= index_in;
      length_ff   <= length_in;
      checksum_ff <= checksum_in;
   end

endmodule

// File: hw/rtl/command_frame_deframer.sv
// ----------------------------------------------------------------------------
// Command frame deframer
// Hunts for framed commands in a received byte stream and reports payload
// bytes and an end-of-frame verdict.
// Path: an accepted request is held in the input register until the result
// register can take its result, which is registered there and drives rsp.
// Throughput: one request per cycle; the input register and the result
// register each advance whenever the result register is empty or drained.
// Reset: synchronous; the parser returns to hunting for a start marker and
// the markers return to their defaults.
// ----------------------------------------------------------------------------
module command_frame_deframer #(
   parameter int BUFFER_BYTES = cfd_pkg::BUFFER_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: rx_byte[7:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cfd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata: payload_byte[7:0], payload_position[14:8], frame_type[22:15],
   // unit_index[30:23], payload_length[46:31], frame_status[48:47], zeros
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cfd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // rsp_tuser: result_kind[0]
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cfd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cfd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cfd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [7:0]          start_marker;
   logic [7:0]          end_marker;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_byte_ff;
   logic [7:0]          in_byte_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   cfd_pkg::result_type out_ff;
   cfd_pkg::result_type out_in;

   logic                out_free;
   logic                step_en;
   logic                req_take;
   logic                res_valid;
   cfd_pkg::result_type res;

   cfd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .start_marker (start_marker),
      .end_marker   (end_marker)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   cfd_parser #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .rx_byte      (in_byte_ff),
      .start_marker (start_marker),
      .end_marker   (end_marker),
      .res_valid    (res_valid),
      .res          (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff && !step_en;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata[7:0];
      end
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;
      if (step_en) begin
         out_valid_in = res_valid;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {7'd0,
                        out_ff.frame_status,
                        out_ff.payload_length,
                        out_ff.unit_index,
                        out_ff.frame_type,
                        out_ff.payload_position,
                        out_ff.payload_byte};

endmodule

// File: tb/command_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// Command frame deframer testbench
// Streams framed and unframed bytes into the deframer under several marker
// settings and idle patterns, predicts every payload byte and frame verdict,
// and checks each result field against the prediction in order.
// ----------------------------------------------------------------------------
module command_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LIMIT   = cfd_pkg::BUFFER_BYTES_DEF;
   localparam int PHASE_BYTES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 300000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [cfd_pkg::REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [cfd_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [cfd_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [cfd_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [cfd_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   command_frame_deframer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   logic [7:0]           pending_bytes[$];
   cfd_pkg::result_type  expected_results[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // Deframer state as the testbench tracks it.
   logic [7:0]  start_marker = cfd_pkg::START_MARKER_RST;
   logic [7:0]  end_marker = cfd_pkg::END_MARKER_RST;
   int unsigned frame_count = 0;
   logic [7:0]  xor_acc = '0;
   logic [7:0]  hdr_type = '0;
   logic [7:0]  hdr_unit = '0;
   logic [15:0] hdr_length = '0;
   logic [7:0]  sum_byte = '0;

   function automatic void push_result(logic kind, logic [7:0] data, logic [6:0] offset,
                                       cfd_pkg::status_type status);
      cfd_pkg::result_type r;
      r.kind             = kind;
      r.payload_byte     = data;
      r.payload_position = offset;
      r.frame_type       = hdr_type;
      r.unit_index       = hdr_unit;
      r.payload_length   = hdr_length;
      r.frame_status     = status;
      expected_results.push_back(r);
   endfunction

   function automatic string result_text(cfd_pkg::result_type r);
      string s;
      s = $sformatf("kind=%0d byte=%h pos=%0d type=%h", r.kind, r.payload_byte,
                    r.payload_position, r.frame_type);
      s = {s, $sformatf(" unit=%h len=%h st=%0d", r.unit_index, r.payload_length,
                        r.frame_status)};
      return s;
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      int unsigned         pos;
      int unsigned         len;
      logic                have_payload;
      cfd_pkg::status_type status;
      have_payload = 1'b0;
      if (frame_count == 0) begin
         if (b == start_marker) begin
            frame_count = 1;
            xor_acc     = '0;
            hdr_type    = '0;
            hdr_unit    = '0;
            hdr_length  = '0;
            sum_byte    = '0;
         end
         return;
      end
      pos = frame_count;
      frame_count++;
      len = hdr_length;
      if (pos == 1) begin
         hdr_type = b;
         xor_acc ^= b;
      end else if (pos == 2) begin
         hdr_unit = b;
         xor_acc ^= b;
      end else if (pos == 3) begin
         hdr_length[15:8] = b;
         xor_acc ^= b;
      end else if (pos == 4) begin
         hdr_length[7:0] = b;
         xor_acc ^= b;
      end else if (pos < cfd_pkg::HEADER_BYTES + len) begin
         xor_acc ^= b;
         have_payload = 1'b1;
      end else if (pos == cfd_pkg::HEADER_BYTES + len) begin
         sum_byte = b;
      end else begin
         if (xor_acc != sum_byte)
            status = cfd_pkg::STATUS_CHECKSUM;
         else if (b != end_marker)
            status = cfd_pkg::STATUS_END_MARK;
         else
            status = cfd_pkg::STATUS_GOOD;
         push_result(cfd_pkg::KIND_VERDICT, '0, '0, status);
         frame_count = 0;
         return;
      end
      // Reaching the buffer limit replaces this byte's payload result with a drop.
      if (frame_count >= FRAME_LIMIT) begin
         push_result(cfd_pkg::KIND_VERDICT, '0, '0, cfd_pkg::STATUS_DROPPED);
         frame_count = 0;
      end else if (have_payload) begin
         push_result(cfd_pkg::KIND_PAYLOAD, b, 7'(pos - cfd_pkg::HEADER_BYTES),
                     cfd_pkg::STATUS_GOOD);
      end
   endfunction

   // Sender: one request per accepted handshake, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      cfd_pkg::result_type got;
      cfd_pkg::result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            deframe_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.kind             = rsp_tuser;
            got.payload_byte     = rsp_tdata[7:0];
            got.payload_position = rsp_tdata[14:8];
            got.frame_type       = rsp_tdata[22:15];
            got.unit_index       = rsp_tdata[30:23];
            got.payload_length   = rsp_tdata[46:31];
            got.frame_status     = cfd_pkg::status_type'(rsp_tdata[48:47]);
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result %s", $realtime, result_text(got));
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                   got.payload_position !== want.payload_position ||
                   got.frame_type !== want.frame_type || got.unit_index !== want.unit_index ||
                   got.payload_length !== want.payload_length ||
                   got.frame_status !== want.frame_status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch expected %s", $realtime, result_text(want));
                     $display("%0t:          actual   %s", $realtime, result_text(got));
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_marker(input logic reg_sel, input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= cfd_pkg::CSR_ADDR_W'({reg_sel, 2'b00});
      csr_pwdata  <= cfd_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == cfd_pkg::REG_START_MARKER)
         start_marker = value;
      else
         end_marker = value;
   endtask

   // Queues one frame; cut, when nonzero, truncates it to that many bytes.
   task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] unit,
                              input logic [15:0] len, input logic [7:0] sum_flip,
                              input logic [7:0] end_byte, input int unsigned cut);
      int unsigned n;
      int unsigned k;
      logic [7:0]  acc;
      logic [7:0]  b;
      n = 7 + int'(len);
      if (n > FRAME_LIMIT)
         n = FRAME_LIMIT;
      if (cut != 0 && cut < n)
         n = cut;
      acc = ftype ^ unit ^ len[15:8] ^ len[7:0];
      for (k = 0; k < n; k++) begin
         if (k == 0)
            b = start_marker;
         else if (k == 1)
            b = ftype;
         else if (k == 2)
            b = unit;
         else if (k == 3)
            b = len[15:8];
         else if (k == 4)
            b = len[7:0];
         else if (k < 5 + int'(len)) begin
            // The second payload byte repeats the start marker as plain data.
            b = (k == 6) ? start_marker : 8'($urandom_range(255));
            acc ^= b;
         end else if (k == 5 + int'(len))
            b = acc ^ sum_flip;
         else
            b = end_byte;
         pending_bytes.push_back(b);
      end
   endtask

   task automatic queue_random_frames();
      int unsigned target;
      int unsigned pick;
      logic [15:0] len;
      logic [7:0]  sum_flip;
      logic [7:0]  end_byte;
      int unsigned cut;
      target = pending_bytes.size() + PHASE_BYTES;
      while (pending_bytes.size() < target) begin
         if ($urandom_range(99) < 30)
            repeat ($urandom_range(3, 1)) pending_bytes.push_back(8'($urandom_range(255)));
         pick = $urandom_range(99);
         if (pick < 3)
            len = ($urandom_range(1) == 0) ? 16'($urandom_range(255, 122))
                                          : {8'($urandom_range(255, 1)), 8'($urandom_range(255))};
         else if (pick < 6)
            len = ($urandom_range(1) == 0) ? 16'(FRAME_LIMIT - 7) : 16'(FRAME_LIMIT - 6);
         else if (pick < 14)
            len = 16'($urandom_range(FRAME_LIMIT - 8, 13));
         else
            len = 16'($urandom_range(12));
         sum_flip = ($urandom_range(99) < 15) ? 8'($urandom_range(255, 1)) : 8'h00;
         end_byte = ($urandom_range(99) < 15) ? end_marker ^ 8'($urandom_range(255, 1))
                                              : end_marker;
         cut = ($urandom_range(99) < 5) ? $urandom_range(7 + int'(len) - 1, 1) : 0;
         queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, sum_flip,
                     end_byte, cut);
      end
   endtask

   task automatic drain();
      while (pending_bytes.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: ignored bytes while hunting, then good, checksum and end-marker verdicts.
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      queue_frame(8'hFF, 8'h00, 16'd2, 8'h00, end_marker, 0);
      queue_frame(8'h00, 8'hFF, 16'd0, 8'hFF, ~end_marker, 0);
      queue_frame(8'h5A, 8'hA5, 16'd0, 8'h00, end_marker ^ 8'h01, 0);
      queue_random_frames();
      drain();

      write_marker(cfd_pkg::REG_START_MARKER, 8'h00);
      write_marker(cfd_pkg::REG_END_MARKER, 8'hFF);
      @(negedge clock);
      send_idle_pct = 67;
      queue_random_frames();
      drain();

      write_marker(cfd_pkg::REG_START_MARKER, 8'hFF);
      write_marker(cfd_pkg::REG_END_MARKER, 8'h00);
      @(negedge clock);
      send_idle_pct  = 0;
      recv_stall_pct = 67;
      queue_random_frames();
      drain();

      write_marker(cfd_pkg::REG_START_MARKER, 8'($urandom_range(255)));
      write_marker(cfd_pkg::REG_END_MARKER, 8'($urandom_range(255)));
      @(negedge clock);
      send_idle_pct  = 30;
      recv_stall_pct = 30;
      queue_random_frames();
      drain();

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
